// ===== design/piecewise_linear_voxel_map_core_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel map assertion macros
// Shared concurrent assertion forms for the voxel map checkers.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_VOXEL_MAP_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_VOXEL_MAP_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define PLVM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high
`define PLVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/plvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel map package
// Widths, register indexes, reset values and stage records of the voxel map.
// ----------------------------------------------------------------------------
`default_nettype none

package plvm_pkg;

   localparam int DATA_W         = 8;
   localparam int REG_W          = 64;
   localparam int CNT_W          = 4;
   localparam int CSR_ADDR_W     = 2;
   localparam int MAX_POINTS_DEF = 8;
   localparam int PROD_W         = 2 * DATA_W;

   // Restoring divider: quotient bits per stage and stage count
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = DATA_W / DIV_STEPS;

   localparam logic [REG_W-1:0] RAW_RESET   = 64'h0000_0000_0000_FF00;
   localparam logic [REG_W-1:0] LEVEL_RESET = 64'h0000_0000_0000_FF00;
   localparam logic [CNT_W-1:0] COUNT_RESET = 4'd2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RAW   = 2'd0,
      CSR_LEVEL = 2'd1,
      CSR_COUNT = 2'd2
   } csr_index_type;

   // Segment choice result
   typedef struct packed {
      logic              bypass;
      logic [DATA_W-1:0] bval;
      logic [DATA_W-1:0] dv;
      logic [DATA_W-1:0] den;
      logic [DATA_W-1:0] mag;
      logic              neg;
      logic [DATA_W-1:0] p0;
   } seg_type;

   // Divider work record; work holds {remainder, dividend/quotient bits}
   typedef struct packed {
      logic              bypass;
      logic [DATA_W-1:0] bval;
      logic [DATA_W-1:0] den;
      logic              neg;
      logic [DATA_W-1:0] p0;
      logic [PROD_W-1:0] work;
   } div_type;

endpackage

`default_nettype wire

// ===== design/plvm_seg_select.sv =====
// ----------------------------------------------------------------------------
// Voxel map segment select
// Compares the voxel against all breakpoints, picks the last holding segment
// and registers the clamp value or the interpolation operands.
// ----------------------------------------------------------------------------
`default_nettype none

module plvm_seg_select
   import plvm_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [DATA_W-1:0] voxel,
   input  wire logic [REG_W-1:0]  raw_breakpoints,
   input  wire logic [REG_W-1:0]  level_points,
   input  wire logic [CNT_W-1:0]  point_count,
   output logic                   out_valid,
   output seg_type                out_seg
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   logic [DATA_W-1:0] raw_b [MAX_POINTS];
   logic [DATA_W-1:0] lvl_b [MAX_POINTS];
   logic [CNT_W-1:0]  n_sat;
   logic [CNT_W-1:0]  last_full;
   logic [IDX_W-1:0]  last;
   logic [IDX_W-1:0]  seg;
   logic [IDX_W-1:0]  seg_hi;
   logic [MAX_POINTS-2:0] hit;
   logic              below;
   logic              above;
   logic [DATA_W-1:0] r0, r1, p0, p1;
   seg_type           seg_in;
   seg_type           seg_ff;
   logic              valid_ff;

   // Unpack breakpoint and level bytes
   always_comb begin
      for (int k = 0; k < MAX_POINTS; k++) begin
         raw_b[k] = raw_breakpoints[k*DATA_W +: DATA_W];
         lvl_b[k] = level_points[k*DATA_W +: DATA_W];
      end
   end

   // Saturate the point count to 2..MAX_POINTS
   always_comb begin
      priority if (point_count < CNT_W'(2)) begin
         n_sat = CNT_W'(2);
      end else if (point_count > CNT_W'(MAX_POINTS)) begin
         n_sat = CNT_W'(MAX_POINTS);
      end else begin
         n_sat = point_count;
      end
      last_full = n_sat - CNT_W'(1);
      last      = last_full[IDX_W-1:0];
   end

   // Parallel segment compares, keep the highest hit
   always_comb begin
      for (int k = 0; k < MAX_POINTS - 1; k++) begin
         hit[k] = (IDX_W'(k) < last) && (voxel >= raw_b[k]) && (voxel <= raw_b[k+1]);
      end
      seg = '0;
      for (int k = 0; k < MAX_POINTS - 1; k++) begin
         if (hit[k]) begin
            seg = IDX_W'(k);
         end
      end
      seg_hi = seg + IDX_W'(1);
   end

   // Pick operands and the clamp value
   always_comb begin
      below = voxel < raw_b[0];
      above = voxel > raw_b[last];
      r0    = raw_b[seg];
      r1    = raw_b[seg_hi];
      p0    = lvl_b[seg];
      p1    = lvl_b[seg_hi];

      seg_in.dv  = voxel - r0;
      seg_in.den = r1 - r0;
      seg_in.p0  = p0;
      if (p1 >= p0) begin
         seg_in.mag = p1 - p0;
         seg_in.neg = 1'b0;
      end else begin
         seg_in.mag = p0 - p1;
         seg_in.neg = 1'b1;
      end

      priority if (below) begin
         seg_in.bypass = 1'b1;
         seg_in.bval   = lvl_b[0];
      end else if (above || !(|hit)) begin
         seg_in.bypass = 1'b1;
         seg_in.bval   = lvl_b[last];
      end else if (r1 == r0) begin
         seg_in.bypass = 1'b1;
         seg_in.bval   = p0;
      end else begin
         seg_in.bypass = 1'b0;
         seg_in.bval   = p0;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         seg_ff <= seg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_seg   = seg_ff;

endmodule

`default_nettype wire

// ===== design/plvm_div_stage.sv =====
// ----------------------------------------------------------------------------
// Voxel map divider stage
// Retires DIV_STEPS quotient bits of the restoring division per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module plvm_div_stage
   import plvm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic enable,
   input  wire logic in_valid,
   input  div_type   in_data,
   output logic      out_valid,
   output div_type   out_data
);

   div_type            data_in;
   div_type            data_ff;
   logic               valid_ff;
   logic [DATA_W:0]    part;
   logic [DATA_W:0]    diff;
   logic [PROD_W-1:0]  work;

   // For each of the DIV_STEPS steps, shift in one dividend bit and subtract the divisor where it fits
   always_comb begin
      data_in = in_data;
      work    = in_data.work;
      part    = '0;
      diff    = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
         part = {work[PROD_W-1:DATA_W], work[DATA_W-1]};
         diff = part - {1'b0, in_data.den};
         if (part >= {1'b0, in_data.den}) begin
            work = {diff[DATA_W-1:0], work[DATA_W-2:0], 1'b1};
         end else begin
            work = {part[DATA_W-1:0], work[DATA_W-2:0], 1'b0};
         end
      end
      data_in.work = work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== design/plvm_skid.sv =====
// ----------------------------------------------------------------------------
// Voxel map output skid buffer
// Output register plus one spare entry, so the pipeline ready is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plvm_skid
   import plvm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [DATA_W-1:0] in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [DATA_W-1:0]      out_data
);

   logic              out_valid_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              skid_valid_ff;
   logic [DATA_W-1:0] skid_data_ff;
   logic              take;
   logic              drain;

   assign in_ready = ~skid_valid_ff;
   assign take     = in_valid & in_ready;
   assign drain    = ~out_valid_ff | out_ready;

   // Refill the output from the spare entry first, else park a stalled request
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         out_valid_ff  <= skid_valid_ff | take;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (take) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== design/piecewise_linear_voxel_map_core.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear voxel map core
// Maps each voxel through a transfer curve of up to MAX_POINTS breakpoints
// with exact floor interpolation.
//
//   channel  dir  payload
//   req_     in   tdata[7:0] voxel
//   rsp_     out  tdata[7:0] mapped_value
//   csr_     in   0 raw_breakpoints, 1 level_points, 2 point_count
//
// One request per cycle while the spare entry is empty; from acceptance to rsp_tvalid
// a request passes the input register, segment select, multiply, four 2-bit divider
// stages and the output register. The divider stage chain sets the depth.
// Synchronous reset clears all valid bits and loads the identity curve.
// A stalled result parks in a spare entry; req_tready is registered and the
// whole pipeline holds while that entry is full.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_voxel_map_core
   import plvm_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [DATA_W-1:0]     req_tdata,   // [7:0] voxel
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [DATA_W-1:0]          rsp_tdata,   // [7:0] mapped_value
   // configuration port
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [REG_W-1:0]      csr_wdata
);

   logic [REG_W-1:0]  raw_ff;
   logic [REG_W-1:0]  level_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              enable;
   logic              s0_valid_ff;
   logic [DATA_W-1:0] s0_voxel_ff;
   logic              s1_valid;
   seg_type           s1_seg;
   logic              s2_valid_ff;
   div_type           s2_in;
   div_type           s2_ff;
   logic              dv_valid [DIV_STAGES+1];
   div_type           dv_data  [DIV_STAGES+1];
   div_type           fin;
   logic [DATA_W-1:0] quo;
   logic [DATA_W-1:0] rem;
   logic [DATA_W-1:0] result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff   <= RAW_RESET;
         level_ff <= LEVEL_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RAW:   raw_ff   <= csr_wdata;
            CSR_LEVEL: level_ff <= csr_wdata;
            CSR_COUNT: count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = enable;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_voxel_ff <= req_tdata;
      end
   end

   // Segment choice
   plvm_seg_select #(
      .MAX_POINTS (MAX_POINTS)
   ) u_seg_select (
      .clock           (clock),
      .reset           (reset),
      .enable          (enable),
      .in_valid        (s0_valid_ff),
      .voxel           (s0_voxel_ff),
      .raw_breakpoints (raw_ff),
      .level_points    (level_ff),
      .point_count     (count_ff),
      .out_valid       (s1_valid),
      .out_seg         (s1_seg)
   );

   // Multiply offset by level span
   always_comb begin
      s2_in.bypass = s1_seg.bypass;
      s2_in.bval   = s1_seg.bval;
      s2_in.den    = s1_seg.den;
      s2_in.neg    = s1_seg.neg;
      s2_in.p0     = s1_seg.p0;
      s2_in.work   = PROD_W'(s1_seg.dv) * PROD_W'(s1_seg.mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_ff <= s2_in;
      end
   end

   assign dv_valid[0] = s2_valid_ff;
   assign dv_data[0]  = s2_ff;

   // Divider chain
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      plvm_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (dv_valid[g]),
         .in_data   (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_data  (dv_data[g+1])
      );
   end

   // Apply the sign; a falling segment rounds toward minus infinity
   always_comb begin
      fin = dv_data[DIV_STAGES];
      quo = fin.work[DATA_W-1:0];
      rem = fin.work[PROD_W-1:DATA_W];
      if (fin.bypass) begin
         result = fin.bval;
      end else if (fin.neg) begin
         result = fin.p0 - quo - DATA_W'(rem != '0);
      end else begin
         result = fin.p0 + quo;
      end
   end

   plvm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid[DIV_STAGES]),
      .in_data   (result),
      .in_ready  (enable),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== design/plvm_monitor.sv =====
// ----------------------------------------------------------------------------
// Voxel map port monitor
// Watches the top-level handshakes and the spare-entry flow control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_linear_voxel_map_core_defines.svh"

module plvm_monitor
   import plvm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tready,
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [DATA_W-1:0] rsp_tdata
);

   // A stalled result holds
   `PLVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // With no result pending the core must take requests
   `PLVM_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "ready low with empty output")

   // A taken result frees the spare entry
   `PLVM_ASSERT_NEXT(a_ready_after_drain, clock, reset, rsp_tready, req_tready, "ready low after drain")

   // Ready drops only after a stalled result
   `PLVM_ASSERT_NOW(a_ready_fall, clock, reset, $fell(req_tready), $past(rsp_tvalid && !rsp_tready), "ready fell without stall")

endmodule

bind piecewise_linear_voxel_map_core plvm_monitor u_monitor (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel map core testbench
// Streams voxels through the piecewise-linear map core under a series of
// transfer curves and compares each mapped level against an in-bench
// prediction of the exact floor interpolation. Covers the identity reset
// curve, segment edge cases, unordered breakpoints, saturated point counts,
// random curves under several handshake idle patterns, and a long output
// stall that fills the pipeline.
// ----------------------------------------------------------------------------

module tb_top;
   import plvm_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int PIPE_LATENCY = 8;
   localparam int MAX_PTS      = MAX_POINTS_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int BATCH_ITEMS  = 60;
   localparam int STALL_CYCLES = 60;

   // Index with no register behind it; writes there must be ignored
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;    // [7:0] voxel
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;          // [7:0] mapped_value
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [REG_W-1:0]      csr_wdata  = '0;

   // Bench copy of the transfer curve
   logic [REG_W-1:0]      curve_raw   = RAW_RESET;
   logic [REG_W-1:0]      curve_level = LEVEL_RESET;
   logic [CNT_W-1:0]      curve_count = COUNT_RESET;

   logic [DATA_W-1:0]     expected_levels[$];
   logic [DATA_W-1:0]     expected_voxels[$];

   int                    tx_idle_pct   = 0;
   int                    rx_idle_pct   = 0;
   int                    hold_request  = 0;
   int                    stall_left    = 0;
   int                    mismatch_count = 0;
   int                    cycle_count   = 0;

   piecewise_linear_voxel_map_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Exact floor interpolation through the bench copy of the curve
   function automatic logic [DATA_W-1:0] map_through_curve(input logic [DATA_W-1:0] voxel);
      int  n;
      int  last_pt;
      int  seg;
      int  a;
      int  b;
      int  r0;
      int  r1;
      int  p0;
      int  p1;
      int  den;
      int  num;
      int  q;
      bit  found;
      n = int'(curve_count);
      if (n < 2) n = 2;
      if (n > MAX_PTS) n = MAX_PTS;
      last_pt = n - 1;
      if (voxel < curve_raw[0 +: 8]) return curve_level[0 +: 8];
      if (voxel > curve_raw[8*last_pt +: 8]) return curve_level[8*last_pt +: 8];
      found = 1'b0;
      seg   = 0;
      for (int k = 0; k < last_pt; k++) begin
         a = int'(curve_raw[8*k +: 8]);
         b = int'(curve_raw[8*(k+1) +: 8]);
         if (voxel >= a && voxel <= b) begin
            seg   = k;
            found = 1'b1;
         end
      end
      if (!found) return curve_level[8*last_pt +: 8];
      r0  = int'(curve_raw[8*seg +: 8]);
      r1  = int'(curve_raw[8*(seg+1) +: 8]);
      p0  = int'(curve_level[8*seg +: 8]);
      p1  = int'(curve_level[8*(seg+1) +: 8]);
      den = r1 - r0;
      if (den <= 0) return DATA_W'(p0);
      num = (int'(voxel) - r0) * (p1 - p0);
      // round toward minus infinity on falling segments
      if (num >= 0) q = num / den;
      else q = -((-num + den - 1) / den);
      return DATA_W'(p0 + q);
   endfunction

   // Sort the eight bytes of a word into ascending order, entry 0 lowest
   function automatic logic [REG_W-1:0] ascending_bytes(input logic [REG_W-1:0] word);
      logic [7:0] tmp;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 7 - i; j++) begin
            if (word[8*j +: 8] > word[8*(j+1) +: 8]) begin
               tmp                = word[8*j +: 8];
               word[8*j +: 8]     = word[8*(j+1) +: 8];
               word[8*(j+1) +: 8] = tmp;
            end
         end
      end
      return word;
   endfunction

   // Write one register; the block must be idle
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [REG_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      if (addr == CSR_RAW) curve_raw = data;
      else if (addr == CSR_LEVEL) curve_level = data;
      else if (addr == CSR_COUNT) curve_count = data[CNT_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_curve(input logic [REG_W-1:0] raw, input logic [REG_W-1:0] level,
                             input logic [REG_W-1:0] count);
      write_csr(CSR_RAW, raw);
      write_csr(CSR_LEVEL, level);
      write_csr(CSR_COUNT, count);
   endtask

   // Offer one voxel request, with random idle cycles ahead of it
   task automatic send_voxel(input logic [DATA_W-1:0] voxel);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= voxel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_levels.push_back(map_through_curve(voxel));
      expected_voxels.push_back(voxel);
   endtask

   // Drop valid, drain all outstanding results, then let the pipe settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Voxel near one of the eight breakpoints, at an extreme, or anywhere
   function automatic logic [DATA_W-1:0] pick_voxel();
      int sel;
      int k;
      sel = $urandom_range(99);
      if (sel < 40) begin
         k = $urandom_range(MAX_PTS - 1);
         return DATA_W'(int'(curve_raw[8*k +: 8]) + $urandom_range(2) - 1);
      end
      if (sel < 48) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      return DATA_W'($urandom_range(255));
   endfunction

   // Mostly ascending curves with random content, sometimes unordered or odd counts
   task automatic load_random_curve();
      logic [REG_W-1:0] raw;
      logic [REG_W-1:0] level;
      logic [REG_W-1:0] count;
      int               sel;
      raw   = {$urandom, $urandom};
      level = {$urandom, $urandom};
      if ($urandom_range(99) < 80) raw = ascending_bytes(raw);
      sel = $urandom_range(99);
      if (sel < 10) level = '0;
      else if (sel < 20) level = '1;
      sel = $urandom_range(99);
      if (sel < 75) count = REG_W'($urandom_range(MAX_PTS, 2));
      else if (sel < 85) count = REG_W'($urandom_range(1));
      else count = REG_W'($urandom_range(15, MAX_PTS + 1));
      // upper data bits beyond the count width are don't-care
      if ($urandom_range(3) == 0) begin
         count[REG_W-1:CNT_W] = (REG_W-CNT_W)'({$urandom, $urandom});
      end
      load_curve(raw, level, count);
   endtask

   // Receiver: random back-pressure plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request != 0) begin
         stall_left   <= hold_request;
         hold_request <= 0;
         rsp_tready   <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Compare each accepted result against the oldest prediction
   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      logic [DATA_W-1:0] voxel;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            $display("%0t: unexpected result mapped_value=%0d", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want  = expected_levels.pop_front();
            voxel = expected_voxels.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: voxel %0d mapped_value expected %0d actual %0d",
                        $time, voxel, want, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("piecewise_linear_voxel_map_core test failed");
         $finish;
      end
   end

   // Reset curve is the identity map
   task automatic test_identity_after_reset();
      send_voxel(8'h00);
      send_voxel(8'hFF);
      send_voxel(8'h55);
      send_voxel(8'hAA);
      wait_idle();
   endtask

   // Below first, above last, rising, falling and zero-width segments
   task automatic test_segment_cases();
      load_curve(64'h0000_0000_63_05_FA_14 << 0 | 64'h0, 64'h0, 64'd4);
      load_curve({32'h0, 8'd200, 8'd200, 8'd100, 8'd10}, {32'h0, 8'd99, 8'd5, 8'd250, 8'd20},
                 64'd4);
      send_voxel(8'd0);
      send_voxel(8'd9);
      send_voxel(8'd10);
      send_voxel(8'd55);
      send_voxel(8'd100);
      send_voxel(8'd150);
      send_voxel(8'd199);
      send_voxel(8'd200);
      send_voxel(8'd201);
      send_voxel(8'd255);
      wait_idle();
   endtask

   // Breakpoints out of order, with a count above the maximum
   task automatic test_unordered_curve();
      load_curve(64'hFF_B0_C0_80_80_30_40_00, 64'h7F_FF_00_F0_10_80_00_FF, 64'd15);
      send_voxel(8'h35);
      send_voxel(8'h80);
      send_voxel(8'hB8);
      send_voxel(8'hFF);
      wait_idle();
   endtask

   // Count below two, all-zero breakpoints, full-scale levels, spare index
   task automatic test_saturated_count();
      load_curve(64'h0, '1, 64'd0);
      write_csr(CSR_SPARE, {$urandom, $urandom});
      send_voxel(8'd0);
      send_voxel(8'd1);
      send_voxel(8'd255);
      wait_idle();
   endtask

   // Random curves and voxels under three idle patterns
   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin
               tx_idle_pct = 36;
               rx_idle_pct = 80;
            end
            1: begin
               tx_idle_pct = 80;
               rx_idle_pct = 36;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int batch = 0; batch < 5; batch++) begin
            load_random_curve();
            repeat (BATCH_ITEMS) send_voxel(pick_voxel());
            wait_idle();
         end
      end
   endtask

   // Hold the receiver off while requests keep coming, so the input stalls
   task automatic test_output_stall();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      load_random_curve();
      hold_request <= STALL_CYCLES;
      repeat (40) send_voxel(pick_voxel());
      wait_idle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_after_reset();
      test_segment_cases();
      test_unordered_curve();
      test_saturated_count();
      test_random_traffic();
      test_output_stall();
      repeat (PIPE_LATENCY * 2) @(posedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("piecewise_linear_voxel_map_core test passed");
      end else begin
         $display("piecewise_linear_voxel_map_core test failed");
      end
      $finish;
   end

endmodule

// ===== piecewise_linear_voxel_map_core.f =====
+incdir+design
design/plvm_pkg.sv
design/plvm_seg_select.sv
design/plvm_div_stage.sv
design/plvm_skid.sv
design/piecewise_linear_voxel_map_core.sv
design/plvm_monitor.sv
bench/tb_top.sv
